[design/svm_pkg.sv]
// Shared types and codes for the sample voice mixer.
package svm_pkg;

  typedef enum logic [1:0] {
    CMD_TRIGGER = 2'd0,
    CMD_SAMPLE  = 2'd1,
    CMD_WORD    = 2'd2,
    CMD_DESC    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX,
    S_PUB
  } state_t;

  typedef logic signed [15:0] sample_t;

  localparam int ADDR_W = 19;
  localparam int LEN_W = 20;
  localparam int SID_W = 3;
  localparam int MASK_W = 8;
  localparam int MIX_SHIFT = 3;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

endpackage

[design/svm_if.sv]
// Request and result channel interfaces of the sample voice mixer.
interface svm_in_if;
  import svm_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [SID_W-1:0]    sound_id;
  logic [ADDR_W-1:0]   address;
  sample_t             sample_word;
  logic [LEN_W-1:0]    sound_len;

  modport source (output valid, command, sound_id, address, sample_word, sound_len,
                  input ready);
  modport sink (input valid, command, sound_id, address, sample_word, sound_len,
                output ready);
endinterface

interface svm_out_if;
  import svm_pkg::*;
  logic                valid;
  logic                ready;
  sample_t             mixed_sample;
  logic                is_sample;
  logic                trigger_dropped;
  logic [MASK_W-1:0]   voices_active;

  modport source (output valid, mixed_sample, is_sample, trigger_dropped, voices_active,
                  input ready);
  modport sink (input valid, mixed_sample, is_sample, trigger_dropped, voices_active,
                output ready);
endinterface

[design/svm_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/sample_voice_mixer.sv]
// Top level of the sample voice mixer: command sequencer, voice memory and sample memory.
//
//   channel   direction  handshake            payload
//   in_ch     in         valid/ready          command, sound_id, address, sample_word, sound_len
//   out_ch    out        valid/ready          mixed_sample, is_sample, trigger_dropped,
//                                             voices_active
//
// Word and descriptor writes complete in the cycle they are accepted.
// A trigger request passes through the publish state before the next request can be accepted.
// A sample request makes one voice memory read per voice, one sample memory read after each,
// then a drain.
// Reset is synchronous and needs no clearing pass; the sample memory is not cleared.
// A request is accepted only when the previous result has entered the output register.
module sample_voice_mixer #(
  parameter int VOICES = 8,
  parameter int SOUNDS = 8,
  parameter int SAMPLE_DEPTH = 524288
) (
  input logic clk,
  input logic rst_n,
  svm_in_if.sink    in_ch,
  svm_out_if.source out_ch
);
  import svm_pkg::*;

  localparam int AW   = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SW   = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
  localparam int CW   = $clog2(VOICES + 1);
  localparam int LW   = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam int XW   = (AW > ADDR_W) ? AW : ADDR_W;
  localparam int SUMW = 16 - MIX_SHIFT + VW + 1;
  localparam int MW   = (VOICES > MASK_W) ? VOICES : MASK_W;
  localparam int VDW  = SW + AW;
  localparam logic signed [SUMW-1:0] SAT_MAX = SUMW'(SAMPLE_MAX);
  localparam logic signed [SUMW-1:0] SAT_MIN = SUMW'(SAMPLE_MIN);

  state_t state_r, state_nxt;

  logic [VOICES-1:0]  active_r;
  logic [ADDR_W-1:0]  start_r [SOUNDS];
  logic [LW-1:0]      len_r [SOUNDS];
  logic [CW-1:0]      cnt_r;
  logic               p1_v_r;
  logic [VW-1:0]      p1_idx_r;
  logic               p2_v_r;
  logic signed [SUMW-1:0] acc_r;
  sample_t            res_sum_r;
  logic               res_is_sample_r;
  logic               res_dropped_r;
  logic               out_valid_r;
  sample_t            out_sum_r;
  logic               out_is_sample_r;
  logic               out_dropped_r;
  logic [MASK_W-1:0]  out_mask_r;

  logic               accept;
  cmd_t               cmd;
  logic [SW-1:0]      sid;
  logic [5:0]         sid_mod;
  logic               free_any;
  logic [VW-1:0]      free_idx;
  logic [LW-1:0]      len_sat;
  logic [XW-1:0]      waddr_x;
  logic [XW-1:0]      start_x;

  logic [VDW-1:0]     vq;
  logic [SW-1:0]      v_snd;
  logic [AW-1:0]      v_pos;
  logic [AW:0]        pos_inc;
  logic               ends;
  logic               s1_go;
  logic               issue;
  logic [AW-1:0]      rd_addr;
  sample_t            sq;
  sample_t            sq_shr;
  sample_t            sum_sat;
  logic [MW-1:0]      act_x;

  logic               in_ready;
  logic               smem_we;
  logic               vmem_we;
  logic [VW-1:0]      vmem_waddr;
  logic [VDW-1:0]     vmem_wdata;
  logic               out_load;
  logic               mix_done;

  assign accept = in_ch.valid && in_ch.ready;
  assign cmd = cmd_t'(in_ch.command);
  assign in_ch.ready = in_ready;

  always_comb begin
    sid_mod = {3'b000, in_ch.sound_id};
    for (int k = 0; k < 8; k++) begin
      if (sid_mod >= 6'(SOUNDS)) begin
        sid_mod = sid_mod - 6'(SOUNDS);
      end
    end
    sid = sid_mod[SW-1:0];
  end

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_any = 1'b1;
        free_idx = VW'(i);
      end
    end
  end

  always_comb begin
    if (LW'(in_ch.sound_len) > LW'(SAMPLE_DEPTH)) begin
      len_sat = LW'(SAMPLE_DEPTH);
    end else begin
      len_sat = LW'(in_ch.sound_len);
    end
  end

  assign waddr_x = XW'(in_ch.address);

  assign v_snd   = vq[VDW-1:AW];
  assign v_pos   = vq[AW-1:0];
  assign start_x = XW'(start_r[v_snd]);
  assign rd_addr = start_x[AW-1:0] + v_pos;
  assign pos_inc = {1'b0, v_pos} + (AW+1)'(1);
  assign ends    = LW'(pos_inc) >= len_r[v_snd];
  assign s1_go   = p1_v_r && active_r[p1_idx_r];
  assign issue   = (state_r == S_MIX) && (cnt_r < CW'(VOICES));

  assign sq_shr = sq >>> MIX_SHIFT;

  always_comb begin
    if (acc_r > SAT_MAX) begin
      sum_sat = 16'sh7fff;
    end else if (acc_r < SAT_MIN) begin
      sum_sat = 16'sh8000;
    end else begin
      sum_sat = acc_r[15:0];
    end
  end

  assign act_x = MW'(active_r);

  svm_ram #(
    .WIDTH (16),
    .DEPTH (SAMPLE_DEPTH)
  ) u_sample_mem (
    .clk   (clk),
    .we    (smem_we),
    .waddr (waddr_x[AW-1:0]),
    .wdata (in_ch.sample_word),
    .raddr (rd_addr),
    .rdata (sq)
  );

  svm_ram #(
    .WIDTH (VDW),
    .DEPTH (VOICES)
  ) u_voice_mem (
    .clk   (clk),
    .we    (vmem_we),
    .waddr (vmem_waddr),
    .wdata (vmem_wdata),
    .raddr (cnt_r[VW-1:0]),
    .rdata (vq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    smem_we    = 1'b0;
    vmem_we    = 1'b0;
    vmem_waddr = p1_idx_r;
    vmem_wdata = {v_snd, ends ? AW'(0) : pos_inc[AW-1:0]};
    out_load   = 1'b0;
    mix_done   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          case (cmd)
            CMD_TRIGGER: begin
              state_nxt = S_PUB;
              if (free_any) begin
                vmem_we    = 1'b1;
                vmem_waddr = free_idx;
                vmem_wdata = {sid, AW'(0)};
              end
            end
            CMD_SAMPLE: state_nxt = S_MIX;
            CMD_WORD:   smem_we = 1'b1;
            default:    ;
          endcase
        end
      end
      S_MIX: begin
        vmem_we = s1_go;
        if (cnt_r == CW'(VOICES) && !p1_v_r && !p2_v_r) begin
          mix_done  = 1'b1;
          state_nxt = S_PUB;
        end
      end
      S_PUB: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < SOUNDS; s++) begin
        start_r[s] <= '0;
        len_r[s]   <= '0;
      end
    end else begin
      p1_v_r <= issue;
      p2_v_r <= s1_go;
      if (issue) begin
        cnt_r    <= cnt_r + CW'(1);
        p1_idx_r <= cnt_r[VW-1:0];
      end
      if (s1_go && ends) begin
        active_r[p1_idx_r] <= 1'b0;
      end
      if (p2_v_r) begin
        acc_r <= acc_r + SUMW'(sq_shr);
      end
      if (mix_done) begin
        res_sum_r <= sum_sat;
      end
      if (accept) begin
        case (cmd)
          CMD_TRIGGER: begin
            if (free_any) begin
              active_r[free_idx] <= 1'b1;
            end
            res_dropped_r   <= !free_any;
            res_is_sample_r <= 1'b0;
            res_sum_r       <= '0;
          end
          CMD_SAMPLE: begin
            cnt_r           <= '0;
            acc_r           <= '0;
            res_dropped_r   <= 1'b0;
            res_is_sample_r <= 1'b1;
          end
          CMD_DESC: begin
            start_r[sid] <= in_ch.address;
            len_r[sid]   <= len_sat;
          end
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r     <= 1'b1;
        out_sum_r       <= res_sum_r;
        out_is_sample_r <= res_is_sample_r;
        out_dropped_r   <= res_dropped_r;
        out_mask_r      <= act_x[MASK_W-1:0];
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.mixed_sample    = out_sum_r;
  assign out_ch.is_sample       = out_is_sample_r;
  assign out_ch.trigger_dropped = out_dropped_r;
  assign out_ch.voices_active   = out_mask_r;

  a_p2_follows_p1: assert property (@(posedge clk) disable iff (!rst_n)
    p2_v_r |-> $past(p1_v_r))
    else $error("sample read stage without a voice read stage");

  a_trigger_adds_voice: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd == CMD_TRIGGER && active_r != '1)
      |=> $countones(active_r) == $past($countones(active_r)) + 1)
    else $error("placed trigger did not start exactly one voice");

  a_no_write_while_mixing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX) |-> !smem_we)
    else $error("sample memory written during a mix");

  a_drop_only_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dropped_r) |-> !out_is_sample_r)
    else $error("sample result flagged as dropped trigger");

endmodule

[bench/svm_checker.sv]
// Checker for the sample voice mixer: predicts each result from the requests and compares.
`timescale 1ns / 1ps

module svm_checker #(
  parameter int VOICES = 8,
  parameter int SOUNDS = 8,
  parameter int SAMPLE_DEPTH = 524288
) (
  input  logic clk,
  input  logic rst_n,
  svm_in_if    in_ch,
  svm_out_if   out_ch,
  output int   fail_cnt,
  output int   pending_cnt
);
  import svm_pkg::*;

  typedef struct packed {
    sample_t           mix;
    logic              is_smp;
    logic              dropped;
    logic [MASK_W-1:0] voices;
  } mix_result_t;

  mix_result_t expected_mix_q[$];
  int          errs;

  bit          voice_on    [VOICES];
  int          voice_snd   [VOICES];
  int unsigned voice_pos   [VOICES];
  int unsigned snd_start   [SOUNDS];
  int unsigned snd_len     [SOUNDS];
  sample_t     sample_mem  [int];

  function automatic logic [MASK_W-1:0] playing_mask();
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < VOICES && i < MASK_W; i++) begin
      m[i] = voice_on[i];
    end
    return m;
  endfunction

  task automatic predict_mix(input logic [1:0] cmd, input logic [SID_W-1:0] sid_in,
                             input logic [ADDR_W-1:0] addr, input sample_t word,
                             input logic [LEN_W-1:0] len);
    int          sid;
    int          s;
    int          a;
    int          sum;
    int unsigned p;
    bit          placed;
    sample_t     rd;
    mix_result_t r;
    sid = sid_in % SOUNDS;
    r = '0;
    case (cmd)
      CMD_WORD: begin
        sample_mem[int'(addr) % SAMPLE_DEPTH] = word;
      end
      CMD_DESC: begin
        snd_start[sid] = 32'(addr);
        snd_len[sid] = (32'(len) > SAMPLE_DEPTH) ? SAMPLE_DEPTH : 32'(len);
      end
      CMD_TRIGGER: begin
        placed = 1'b0;
        for (int i = 0; i < VOICES; i++) begin
          if (!placed && !voice_on[i]) begin
            voice_on[i] = 1'b1;
            voice_snd[i] = sid;
            voice_pos[i] = 0;
            placed = 1'b1;
          end
        end
        r.dropped = !placed;
        r.voices = playing_mask();
        expected_mix_q.push_back(r);
      end
      default: begin
        sum = 0;
        for (int i = 0; i < VOICES; i++) begin
          if (voice_on[i]) begin
            s = voice_snd[i] % SOUNDS;
            a = int'((longint'(snd_start[s]) + voice_pos[i]) % SAMPLE_DEPTH);
            rd = sample_mem.exists(a) ? sample_mem[a] : '0;
            sum += rd >>> MIX_SHIFT;
            p = voice_pos[i] + 1;
            if (p >= snd_len[s]) begin
              voice_on[i] = 1'b0;
              voice_pos[i] = 0;
            end else begin
              voice_pos[i] = p;
            end
          end
        end
        if (sum > SAMPLE_MAX) sum = SAMPLE_MAX;
        if (sum < SAMPLE_MIN) sum = SAMPLE_MIN;
        r.mix = sample_t'(sum);
        r.is_smp = 1'b1;
        r.voices = playing_mask();
        expected_mix_q.push_back(r);
      end
    endcase
  endtask

  always @(posedge clk) begin
    mix_result_t got;
    mix_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        voice_on[i] = 1'b0;
        voice_snd[i] = 0;
        voice_pos[i] = 0;
      end
      for (int i = 0; i < SOUNDS; i++) begin
        snd_start[i] = 0;
        snd_len[i] = 0;
      end
      expected_mix_q.delete();
      errs = 0;
      fail_cnt <= 0;
      pending_cnt <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_mix(in_ch.command, in_ch.sound_id, in_ch.address, in_ch.sample_word,
                    in_ch.sound_len);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.mixed_sample, out_ch.is_sample, out_ch.trigger_dropped,
                out_ch.voices_active};
        if (expected_mix_q.size() == 0) begin
          $display("%0t: expected none, actual mix %0d sample %0b dropped %0b voices %h",
                   $time, got.mix, got.is_smp, got.dropped, got.voices);
          errs++;
        end else begin
          want = expected_mix_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected mix %0d sample %0b dropped %0b voices %h",
                     $time, want.mix, want.is_smp, want.dropped, want.voices);
            $display("%0t:           actual   mix %0d sample %0b dropped %0b voices %h",
                     $time, got.mix, got.is_smp, got.dropped, got.voices);
            errs++;
          end
        end
      end
      fail_cnt <= errs;
      pending_cnt <= expected_mix_q.size();
    end
  end

endmodule

[bench/tb_sample_voice_mixer.sv]
// Testbench top for the sample voice mixer: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_sample_voice_mixer;
  import svm_pkg::*;

  localparam int VOICES = 8;
  localparam int SOUNDS = 8;
  localparam int SAMPLE_DEPTH = 524288;
  localparam int ITEMS = 1800;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic rdy = 1'b0;
  int   hold = 0;
  bit   quiet = 1'b0;
  int   fails;
  int   pending;
  int   sent = 0;

  // What the stimulus knows of the voices, so that it only plays written words.
  bit          play_on    [VOICES];
  int          play_snd   [VOICES];
  int unsigned play_pos   [VOICES];
  int unsigned desc_start [SOUNDS];
  int unsigned desc_len   [SOUNDS];
  bit          loaded     [int];

  svm_in_if  in_ch ();
  svm_out_if out_ch ();

  assign out_ch.ready = rdy;

  sample_voice_mixer #(
    .VOICES(VOICES),
    .SOUNDS(SOUNDS),
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  svm_checker #(
    .VOICES(VOICES),
    .SOUNDS(SOUNDS),
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .fail_cnt(fails),
    .pending_cnt(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      rdy <= 1'b1;
      hold <= 0;
    end else if (rdy && out_ch.valid) begin
      stall = quiet ? 0 : $urandom_range(0, 3);
      hold <= stall;
      rdy <= (stall == 0);
    end else if (rdy) begin
      if (!quiet && $urandom_range(0, 7) == 0) begin
        hold <= $urandom_range(1, 3);
        rdy <= 1'b0;
      end
    end else begin
      hold <= hold - 1;
      rdy <= (hold <= 1);
    end
  end

  function automatic sample_t pick_word();
    case ($urandom_range(0, 9))
      0: return sample_t'(SAMPLE_MAX);
      1: return sample_t'(SAMPLE_MIN);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic drive_req(input cmd_t cmd, input logic [SID_W-1:0] sid,
                           input logic [ADDR_W-1:0] addr, input sample_t word,
                           input logic [LEN_W-1:0] len);
    int gap;
    int s;
    bit placed;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.sound_id <= sid;
    in_ch.address <= addr;
    in_ch.sample_word <= word;
    in_ch.sound_len <= len;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent++;
    s = sid % SOUNDS;
    case (cmd)
      CMD_WORD: begin
        loaded[int'(addr) % SAMPLE_DEPTH] = 1'b1;
      end
      CMD_DESC: begin
        desc_start[s] = 32'(addr);
        desc_len[s] = (32'(len) > SAMPLE_DEPTH) ? SAMPLE_DEPTH : 32'(len);
      end
      CMD_TRIGGER: begin
        placed = 1'b0;
        for (int i = 0; i < VOICES; i++) begin
          if (!placed && !play_on[i]) begin
            play_on[i] = 1'b1;
            play_snd[i] = s;
            play_pos[i] = 0;
            placed = 1'b1;
          end
        end
      end
      default: begin
        for (int i = 0; i < VOICES; i++) begin
          if (play_on[i]) begin
            play_pos[i]++;
            if (play_pos[i] >= desc_len[play_snd[i]]) begin
              play_on[i] = 1'b0;
              play_pos[i] = 0;
            end
          end
        end
      end
    endcase
  endtask

  // Every word that the next mix reads is written first, with random content.
  task automatic mix_once();
    int a;
    for (int i = 0; i < VOICES; i++) begin
      if (play_on[i]) begin
        a = int'((longint'(desc_start[play_snd[i]]) + play_pos[i]) % SAMPLE_DEPTH);
        if (!loaded.exists(a)) begin
          drive_req(CMD_WORD, SID_W'($urandom_range(0, 7)), ADDR_W'(a), pick_word(),
                    LEN_W'($urandom));
        end
      end
    end
    drive_req(CMD_SAMPLE, SID_W'($urandom_range(0, 7)), ADDR_W'($urandom),
              sample_t'($urandom), LEN_W'($urandom));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int pick;
    int next_phase;
    bit paused;
    logic [ADDR_W-1:0] st;
    logic [LEN_W-1:0] ln;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_TRIGGER;
    in_ch.sound_id <= '0;
    in_ch.address <= '0;
    in_ch.sample_word <= '0;
    in_ch.sound_len <= '0;
    for (int i = 0; i < VOICES; i++) begin
      play_on[i] = 1'b0;
      play_snd[i] = 0;
      play_pos[i] = 0;
    end
    for (int i = 0; i < SOUNDS; i++) begin
      desc_start[i] = 0;
      desc_len[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Zero length on the reset descriptor, then wrapped reads and saturated lengths.
    drive_req(CMD_WORD, 3'd0, '0, sample_t'(SAMPLE_MIN), '0);
    drive_req(CMD_WORD, 3'd7, ADDR_MAX, sample_t'(SAMPLE_MAX), LEN_MAX);
    drive_req(CMD_WORD, 3'd2, 19'd1, -16'sd1, 20'd5);
    drive_req(CMD_TRIGGER, 3'd7, ADDR_MAX, '1, LEN_MAX);
    mix_once();
    drive_req(CMD_DESC, 3'd0, ADDR_MAX, '0, 20'd3);
    drive_req(CMD_DESC, 3'd7, 19'd2, '1, LEN_MAX);
    drive_req(CMD_DESC, 3'd3, '0, '0, 20'(SAMPLE_DEPTH));
    drive_req(CMD_TRIGGER, 3'd0, '0, '0, '0);
    drive_req(CMD_TRIGGER, 3'd7, '0, '0, '0);
    drive_req(CMD_TRIGGER, 3'd3, '0, '0, '0);
    for (int i = 1; i < 7; i++) begin
      if (i != 3) drive_req(CMD_TRIGGER, 3'(i), ADDR_W'($urandom), sample_t'($urandom),
                            LEN_W'($urandom));
    end
    drive_req(CMD_TRIGGER, 3'd4, '0, '0, '0);
    repeat (3) mix_once();
    // The sound of a playing voice is redescribed under it.
    drive_req(CMD_DESC, 3'd7, 19'd100, '0, 20'd1);
    repeat (2) mix_once();

    next_phase = sent;
    paused = 1'b0;
    while (sent < ITEMS) begin
      if (sent >= next_phase) begin
        quiet = ($urandom_range(0, 3) == 0);
        next_phase += 150;
      end
      if (!paused && sent >= ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        mix_once();
      end else if (pick < 65) begin
        drive_req(CMD_TRIGGER, SID_W'($urandom_range(0, 7)), ADDR_W'($urandom),
                  sample_t'($urandom), LEN_W'($urandom));
      end else if (pick < 85) begin
        if ($urandom_range(0, 1) == 0) begin
          st = ADDR_W'($urandom);
        end else begin
          st = ADDR_W'((desc_start[$urandom_range(0, SOUNDS - 1)] + $urandom_range(0, 15))
                       % SAMPLE_DEPTH);
        end
        drive_req(CMD_WORD, SID_W'($urandom_range(0, 7)), st, pick_word(), LEN_W'($urandom));
      end else begin
        case ($urandom_range(0, 5))
          0: st = ADDR_MAX - ADDR_W'($urandom_range(0, 6));
          1: st = ADDR_W'($urandom_range(0, 31));
          default: st = ADDR_W'($urandom);
        endcase
        case ($urandom_range(0, 19))
          0: ln = '0;
          1: ln = 20'(SAMPLE_DEPTH);
          2: ln = LEN_W'($urandom_range(SAMPLE_DEPTH + 1, 20'hFFFFF));
          3: ln = LEN_W'($urandom_range(13, 300));
          default: ln = LEN_W'($urandom_range(1, 12));
        endcase
        drive_req(CMD_DESC, SID_W'($urandom_range(0, 7)), st, sample_t'($urandom), ln);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
